@@ hdl/stt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  localparam int STT_TABLE_ENTRIES = 2048;
  localparam int STT_MOVE_BITS     = 16;

  localparam logic [14:0] THR_RESET = 15'd30000;

  // operation codes
  localparam logic [2:0] FUNC_LOOKUP  = 3'd0;
  localparam logic [2:0] FUNC_PROBE   = 3'd1;
  localparam logic [2:0] FUNC_STORE   = 3'd2;
  localparam logic [2:0] FUNC_ADVANCE = 3'd3;
  localparam logic [2:0] FUNC_CLEAR   = 3'd4;

  // bound codes
  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;

  typedef struct packed {
    logic        [2:0]  func;
    logic        [63:0] pos_key;
    logic signed [7:0]  search_depth;
    logic        [6:0]  ply;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] new_score;
    logic        [15:0] new_move;
    logic        [1:0]  bound_type;
  } stt_in_t;

  typedef struct packed {
    logic               score_usable;
    logic               key_match;
    logic signed [15:0] score_out;
    logic        [15:0] move_out;
  } stt_out_t;

  // fixed-width part of one table slot, the move lives in its own memory
  typedef struct packed {
    logic        [63:0] key;
    logic signed [15:0] score;
    logic signed [7:0]  depth;
    logic        [1:0]  bound;
    logic        [7:0]  age;
  } stt_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_ADJUST,
    ST_FINISH,
    ST_CLEAR
  } stt_state_t;

endpackage

`default_nettype wire

@@ hdl/stt_keymod.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stt_keymod #(
  parameter int TABLE_ENTRIES = stt_pkg::STT_TABLE_ENTRIES,
  parameter int IDX_W         = 11
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [63:0]       key,
  output logic                   done,
  output logic [IDX_W-1:0]       index
);

  import stt_pkg::*;

  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      logic             done_r;
      logic [IDX_W-1:0] index_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          index_r <= IDX_W'(key & 64'(TABLE_ENTRIES - 1));
        end
      end

      assign done  = done_r;
      assign index = index_r;
    end else begin : g_serial
      // restoring remainder, eight key bits per cycle, msb first
      localparam int RW = IDX_W + 1;

      logic          busy_r;
      logic          done_r;
      logic [2:0]    cnt_r;
      logic [63:0]   key_r;
      logic [RW-1:0] rem_r;
      logic [RW-1:0] rem_nxt;

      always_comb begin
        rem_nxt = rem_r;
        for (int i = 0; i < 8; i++) begin
          rem_nxt = {rem_nxt[RW-2:0], key_r[63-i]};
          if (rem_nxt >= RW'(TABLE_ENTRIES)) begin
            rem_nxt = rem_nxt - RW'(TABLE_ENTRIES);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r <= 1'b1;
            cnt_r  <= '0;
          end else if (busy_r) begin
            cnt_r <= cnt_r + 3'd1;
            if (cnt_r == 3'd7) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          key_r <= key;
          rem_r <= '0;
        end else if (busy_r) begin
          key_r <= key_r << 8;
          rem_r <= rem_nxt;
        end
      end

      assign done  = done_r;
      assign index = rem_r[IDX_W-1:0];
    end
  endgenerate

endmodule

`default_nettype wire

@@ hdl/stt_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stt_engine #(
  parameter int TABLE_ENTRIES = stt_pkg::STT_TABLE_ENTRIES,
  parameter int MOVE_BITS     = stt_pkg::STT_MOVE_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [14:0]      mate_threshold,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire stt_pkg::stt_in_t in_word,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output stt_pkg::stt_out_t     out_word
);

  import stt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  stt_state_t state_r, state_nxt;

  stt_in_t          item_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] clr_cnt_r;
  logic [7:0]       age_r;

  stt_entry_t           fix_mem  [TABLE_ENTRIES];
  logic [MOVE_BITS-1:0] move_mem [TABLE_ENTRIES];
  stt_entry_t           rd_fix_r;
  logic [MOVE_BITS-1:0] rd_move_r;

  logic signed [15:0] adj_r;
  logic               match_r;
  logic               depth_ok_r;
  logic               replace_r;

  logic     out_valid_r;
  stt_out_t out_word_r;
  stt_out_t res;

  logic                 accept;
  logic                 fin_go;
  logic                 clr_last;
  logic                 key_start;
  logic                 key_done;
  logic [IDX_W-1:0]     key_index;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  stt_entry_t           wr_fix;
  logic [MOVE_BITS-1:0] wr_move;
  logic [MOVE_BITS-1:0] new_move;

  logic        [6:0]  ply_eff;
  logic signed [17:0] s_x, t_x, p_x, r_x;
  logic signed [15:0] adj_nxt;

  stt_keymod #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_keymod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(key_start),
    .key  (in_word.pos_key),
    .done (key_done),
    .index(key_index)
  );

  assign accept   = in_valid && !in_stall;
  assign fin_go   = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  assign clr_last = clr_cnt_r == IDX_W'(TABLE_ENTRIES - 1);
  assign new_move = MOVE_BITS'(item_r.new_move);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_HASH;
      ST_HASH:   if (key_done) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_ADJUST;
      ST_ADJUST: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (fin_go) begin
          state_nxt = (item_r.func == FUNC_CLEAR) ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    key_start = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_fix    = '0;
    wr_move   = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        key_start = in_valid;
      end
      ST_FINISH: begin
        wr_en        = fin_go && (item_r.func == FUNC_STORE) && replace_r;
        wr_fix.key   = item_r.pos_key;
        wr_fix.score = item_r.new_score;
        wr_fix.depth = item_r.search_depth;
        wr_fix.bound = item_r.bound_type;
        wr_fix.age   = age_r;
        wr_move      = (new_move != '0) ? new_move : rd_move_r;
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // mate-distance adjustment with saturation
  always_comb begin
    ply_eff = (item_r.func == FUNC_PROBE) ? 7'd0 : item_r.ply;
    s_x     = 18'(rd_fix_r.score);
    t_x     = $signed({3'b000, mate_threshold});
    p_x     = $signed({11'd0, ply_eff});
    if (s_x >= t_x) begin
      r_x = s_x - p_x;
    end else if (s_x <= -t_x) begin
      r_x = s_x + p_x;
    end else begin
      r_x = s_x;
    end
    if (r_x > 18'sd32767) begin
      adj_nxt = 16'sh7fff;
    end else if (r_x < -18'sd32768) begin
      adj_nxt = 16'sh8000;
    end else begin
      adj_nxt = r_x[15:0];
    end
  end

  // result word
  always_comb begin
    res = '0;
    case (item_r.func)
      FUNC_PROBE: begin
        if (match_r) begin
          res.key_match    = 1'b1;
          res.score_usable = 1'b1;
          res.score_out    = adj_r;
          res.move_out     = 16'(rd_move_r);
        end
      end
      FUNC_LOOKUP: begin
        if (match_r) begin
          res.key_match = 1'b1;
          res.move_out  = 16'(rd_move_r);
          if (depth_ok_r &&
              ((rd_fix_r.bound == BOUND_EXACT) ||
               (rd_fix_r.bound == BOUND_UPPER && adj_r <= item_r.alpha) ||
               (rd_fix_r.bound == BOUND_LOWER && adj_r >= item_r.beta))) begin
            res.score_usable = 1'b1;
            res.score_out    = adj_r;
          end
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      age_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      if (fin_go && item_r.func == FUNC_CLEAR) begin
        clr_cnt_r <= '0;
        age_r     <= '0;
      end else if (fin_go && item_r.func == FUNC_ADVANCE) begin
        age_r <= age_r + 8'd1;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_word;
    end
    if (key_done) begin
      idx_r <= key_index;
    end
    if (state_r == ST_ADJUST) begin
      adj_r      <= adj_nxt;
      match_r    <= rd_fix_r.key == item_r.pos_key;
      depth_ok_r <= rd_fix_r.depth >= item_r.search_depth;
      replace_r  <= (rd_fix_r.key == 64'd0) || (rd_fix_r.key == item_r.pos_key) ||
                    (item_r.search_depth >= rd_fix_r.depth) || (rd_fix_r.age != age_r);
    end
    if (fin_go) begin
      out_word_r <= res;
    end
  end

  // table memories; one item at a time, so a write lands before the next read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fix_mem[wr_addr]  <= wr_fix;
      move_mem[wr_addr] <= wr_move;
    end
    if (state_r == ST_READ) begin
      rd_fix_r  <= fix_mem[idx_r];
      rd_move_r <= move_mem[idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_no_match_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.key_match |->
      out_word_r.move_out == 16'd0 && !out_word_r.score_usable)
    else $error("miss word carries move or usable score");

  a_unusable_zero_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.score_usable |-> out_word_r.score_out == 16'sd0)
    else $error("unusable word carries a score");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == ST_FINISH || state_r == ST_CLEAR)
    else $error("table write outside store or clear");

  a_hash_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    key_done |-> state_r == ST_HASH)
    else $error("slot index ready outside hash state");

  a_clear_resets_age: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> age_r == 8'd0)
    else $error("age not zero during clear");

endmodule

`default_nettype wire

@@ hdl/search_transposition_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// direct-mapped transposition table, one operation per input word.
// input channel: in_valid / in_stall / in_word, taken when in_valid is high and
// in_stall is low. every word gives exactly one result word on out_valid /
// out_stall / out_word; the result is held while out_stall is high, and the
// next input word is taken while an older result still waits.
// cfg_wr_en / cfg_wr_data write mate_threshold (reset 30000). the user must write
// it only while idle; the block itself does not enforce this. one word at a time:
// slot index, memory read, score adjust, then finish. with a power-of-two entry
// count the slot index is the masked low key bits, registered; otherwise the key
// remainder runs eight bits a cycle. the next word is taken only after the
// finish state. a store that replaces its slot writes back in its finish cycle,
// before the next word reads. after reset, and after a clear word, a clearing
// pass writes every slot to zero, one slot a cycle, with in_stall high. a clear
// word's result comes out as its pass starts.
// the finish cycle waits while the output register is full and stalled.

module search_transposition_table #(
  parameter int TABLE_ENTRIES = stt_pkg::STT_TABLE_ENTRIES,
  parameter int MOVE_BITS     = stt_pkg::STT_MOVE_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [14:0]      cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire stt_pkg::stt_in_t in_word,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output stt_pkg::stt_out_t     out_word
);

  import stt_pkg::*;

  logic [14:0] mate_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mate_threshold_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      mate_threshold_r <= cfg_wr_data;
    end
  end

  stt_engine #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MOVE_BITS    (MOVE_BITS)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .mate_threshold(mate_threshold_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word)
  );

endmodule

`default_nettype wire

@@ tb/sv/search_transposition_table_tb.sv @@
`timescale 1ns / 1ps

module search_transposition_table_tb;
  import stt_pkg::*;

  localparam int QUIET_LIMIT   = 20000;
  localparam int KEY_POOL_SIZE = 32;
  localparam int CHUNK_WORDS   = 220;
  localparam int MAX_REPORTS   = 40;

  localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [1:0] BOUND_INVALID     = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [14:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  stt_in_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  stt_out_t out_word;

  always #2 clk = ~clk;

  search_transposition_table u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

  // table image kept in step with every accepted word
  logic        [63:0] slot_key   [STT_TABLE_ENTRIES];
  logic        [15:0] slot_move  [STT_TABLE_ENTRIES];
  logic signed [15:0] slot_score [STT_TABLE_ENTRIES];
  logic signed [7:0]  slot_depth [STT_TABLE_ENTRIES];
  logic        [1:0]  slot_bound [STT_TABLE_ENTRIES];
  logic        [7:0]  slot_age   [STT_TABLE_ENTRIES];
  logic        [7:0]  table_age;
  logic        [14:0] mate_limit = THR_RESET;

  stt_in_t  pending_words[$];
  stt_out_t expected_results[$];
  logic [63:0] key_pool [KEY_POOL_SIZE];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  int n_words = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_usable = 0;
  int n_taken = 0;
  int n_refused = 0;
  int n_clears = 0;

  function automatic void wipe_table();
    for (int i = 0; i < STT_TABLE_ENTRIES; i++) begin
      slot_key[i]   = '0;
      slot_move[i]  = '0;
      slot_score[i] = '0;
      slot_depth[i] = '0;
      slot_bound[i] = '0;
      slot_age[i]   = '0;
    end
    table_age = '0;
  endfunction

  function automatic int mate_adjust(int s, int p);
    int lim;
    int r;
    lim = int'(mate_limit);
    r = s;
    if (s >= lim) r = s - p;
    else if (s <= -lim) r = s + p;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic stt_out_t predict_result(stt_in_t w);
    stt_out_t r;
    int slot;
    int adj;
    logic hit;
    logic take;
    logic [1:0] b;
    r = '0;
    slot = int'(w.pos_key % 64'(STT_TABLE_ENTRIES));
    hit = (slot_key[slot] == w.pos_key);
    b = slot_bound[slot];
    case (w.func)
      FUNC_LOOKUP, FUNC_PROBE: begin
        if (hit) begin
          r.key_match = 1'b1;
          r.move_out = slot_move[slot];
          if (w.func == FUNC_PROBE) begin
            r.score_usable = 1'b1;
            r.score_out = 16'(mate_adjust(slot_score[slot], 0));
          end else if (int'(slot_depth[slot]) >= int'(w.search_depth)) begin
            adj = mate_adjust(slot_score[slot], int'(w.ply));
            if (b == BOUND_EXACT || (b == BOUND_UPPER && adj <= int'(w.alpha)) ||
                (b == BOUND_LOWER && adj >= int'(w.beta))) begin
              r.score_usable = 1'b1;
              r.score_out = 16'(adj);
              n_usable++;
            end
          end
        end
      end
      FUNC_STORE: begin
        take = slot_key[slot] == '0 || hit ||
               int'(w.search_depth) >= int'(slot_depth[slot]) ||
               slot_age[slot] != table_age;
        if (take) begin
          slot_key[slot] = w.pos_key;
          if (w.new_move != '0) slot_move[slot] = w.new_move;
          slot_score[slot] = w.new_score;
          slot_depth[slot] = w.search_depth;
          slot_bound[slot] = w.bound_type;
          slot_age[slot]   = table_age;
          n_taken++;
        end else begin
          n_refused++;
        end
      end
      FUNC_ADVANCE: table_age = table_age + 8'd1;
      FUNC_CLEAR: begin
        wipe_table();
        n_clears++;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stt_in_t make_word(logic [2:0] f, logic [63:0] key, int depth, int ply,
                                        int alpha, int beta, int score, logic [15:0] move,
                                        logic [1:0] bound);
    stt_in_t w;
    w.func         = f;
    w.pos_key      = key;
    w.search_depth = 8'(depth);
    w.ply          = 7'(ply);
    w.alpha        = 16'(alpha);
    w.beta         = 16'(beta);
    w.new_score    = 16'(score);
    w.new_move     = move;
    w.bound_type   = bound;
    return w;
  endfunction

  // scores cluster around the mate threshold, zero and the 16-bit extremes, or are uniform
  function automatic logic signed [15:0] pick_score();
    int s;
    int lim;
    lim = int'(mate_limit);
    case ($urandom_range(5))
      0: s = int'($urandom_range(65535)) - 32768;
      1: s = lim + int'($urandom_range(2)) - 1;
      2: s = 1 - lim - int'($urandom_range(2));
      3: s = $urandom_range(1) ? 32767 : -32768;
      4: s = int'($urandom_range(400)) - 200;
      default: begin
        s = lim - 127 + int'($urandom_range(254));
        if ($urandom_range(1)) s = -s;
      end
    endcase
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return 16'(s);
  endfunction

  function automatic stt_in_t random_word();
    stt_in_t w;
    int r;
    r = $urandom_range(99);
    if (r < 33) w.func = FUNC_STORE;
    else if (r < 66) w.func = FUNC_LOOKUP;
    else if (r < 84) w.func = FUNC_PROBE;
    else if (r < 93) w.func = FUNC_ADVANCE;
    else if (r < 94) w.func = FUNC_CLEAR;
    else w.func = FUNC_UNUSED_FIRST + 3'($urandom_range(2));
    r = $urandom_range(99);
    if (r < 80) w.pos_key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    else if (r < 95) w.pos_key = {$urandom, $urandom};
    else w.pos_key = '0;
    w.search_depth = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(12) - 4);
    w.ply          = 7'($urandom_range(127));
    w.alpha        = pick_score();
    w.beta         = pick_score();
    w.new_score    = pick_score();
    w.new_move     = ($urandom_range(4) == 0) ? 16'h0 : 16'($urandom);
    w.bound_type   = 2'($urandom_range(3));
    return w;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // wait until nothing is queued or in flight and the block takes input again
  task automatic settle_block();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_mate_limit(input logic [14:0] v);
    settle_block();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    mate_limit = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      // sender holds off once per chunk until the table has answered everything
      if (i == count / 2) settle_block();
      pending_words.push_back(random_word());
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_result(in_word));
        n_words++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    stt_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (expected_results.size() == 0) begin
          n_errors++;
          $display("%0t: result word with none expected, got %0h", $time, out_word);
        end else begin
          want = expected_results.pop_front();
          check_field("score_usable", 16'(want.score_usable), 16'(out_word.score_usable));
          check_field("key_match", 16'(want.key_match), 16'(out_word.key_match));
          check_field("score_out", want.score_out, out_word.score_out);
          check_field("move_out", want.move_out, out_word.move_out);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles without a handshake", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [63:0] ka;
    logic [63:0] kb;
    logic [63:0] kd;
    logic [63:0] ke;
    int hot_slot [8];
    ka = 64'h8000_0000_0000_0155;
    kb = 64'h0123_4567_89AB_C155;
    kd = 64'h7FFF_0000_0000_03AA;
    ke = 64'h0000_FFFF_0000_03AA;
    wipe_table();
    // a few hot slots so keys collide and replacement gets exercised
    hot_slot[0] = 0;
    hot_slot[1] = STT_TABLE_ENTRIES - 1;
    for (int i = 2; i < 8; i++) hot_slot[i] = $urandom_range(STT_TABLE_ENTRIES - 1);
    for (int i = 0; i < KEY_POOL_SIZE; i++) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][10:0] = 11'(hot_slot[i % 8]);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 87;
    settle_block();

    // directed: empty slot, extremes, every bound and func, replacement rules
    pending_words.push_back(make_word(FUNC_LOOKUP, '0, 0, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_PROBE, '1, 0, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_STORE, ka, 127, 0, 0, 0, 30000, 16'hFFFF,
                                      BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_LOOKUP, ka, 127, 127, 0, 0, 0, 16'h0, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_PROBE, ka, 0, 127, 0, 0, 0, 16'h0, BOUND_EXACT));
    // move of zero keeps the old move
    pending_words.push_back(make_word(FUNC_STORE, ka, -128, 0, 0, 0, -32768, 16'h0,
                                      BOUND_UPPER));
    pending_words.push_back(make_word(FUNC_LOOKUP, ka, -128, 127, 32767, 0, 0, 16'h0,
                                      BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_LOOKUP, ka, -128, 3, -32768, 0, 0, 16'h0,
                                      BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_LOOKUP, ka, -127, 0, 32767, 0, 0, 16'h0,
                                      BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_STORE, ka, 100, 0, 0, 0, 500, 16'h1234,
                                      BOUND_LOWER));
    pending_words.push_back(make_word(FUNC_LOOKUP, ka, 100, 0, 0, 500, 0, 16'h0, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_LOOKUP, ka, 100, 0, 0, 501, 0, 16'h0, BOUND_EXACT));
    // shallower store of another key into the same slot, same age: refused
    pending_words.push_back(make_word(FUNC_STORE, kb, 50, 0, 0, 0, -200, 16'h0001,
                                      BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_LOOKUP, kb, 0, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_ADVANCE, '0, 0, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_STORE, kb, 50, 0, 0, 0, -200, 16'h0001,
                                      BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_LOOKUP, kb, 50, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_STORE, '1, 5, 0, 0, 0, 77, 16'h0009,
                                      BOUND_INVALID));
    pending_words.push_back(make_word(FUNC_LOOKUP, '1, 0, 0, 32767, -32768, 0, 16'h0,
                                      BOUND_EXACT));
    for (int i = 0; i < 3; i++)
      pending_words.push_back(make_word(FUNC_UNUSED_FIRST + 3'(i), ka, 0, 0, 0, 0, 0, 16'hFFFF,
                                        BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_CLEAR, '0, 0, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_PROBE, ka, 0, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
    settle_block();

    // age wraps after 256 advances, so a shallow store is refused again
    pending_words.push_back(make_word(FUNC_STORE, kd, 20, 0, 0, 0, 1000, 16'h00AA,
                                      BOUND_EXACT));
    for (int i = 0; i < 256; i++)
      pending_words.push_back(make_word(FUNC_ADVANCE, '0, 0, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_STORE, ke, 3, 0, 0, 0, 5, 16'h00BB, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_LOOKUP, ke, 0, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_LOOKUP, kd, 20, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_ADVANCE, '0, 0, 0, 0, 0, 0, 16'h0, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_STORE, ke, 3, 0, 0, 0, 5, 16'h00BB, BOUND_EXACT));
    pending_words.push_back(make_word(FUNC_PROBE, ke, 0, 0, 0, 0, 0, 16'h0, BOUND_EXACT));

    set_mate_limit(15'd0);
    run_random(CHUNK_WORDS);
    set_mate_limit(15'd32767);
    run_random(CHUNK_WORDS);

    send_idle_pct = 87;
    recv_idle_pct = 27;
    set_mate_limit(15'($urandom_range(32767)));
    run_random(CHUNK_WORDS);
    set_mate_limit(15'd1);
    run_random(CHUNK_WORDS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_mate_limit(THR_RESET);
    run_random(CHUNK_WORDS);
    set_mate_limit(15'($urandom_range(32767)));
    run_random(CHUNK_WORDS);

    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d words: %0d usable lookups, %0d stores taken, %0d refused, %0d clears",
             n_words, n_usable, n_taken, n_refused, n_clears);
    $display("%0d result words compared, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
